>>> src/cdcb_pkg.sv
// Shared types, command codes and reply tables of the CD changer bus responder.
`default_nettype none
package cdcb_pkg;

   // Command codes, also shown on the result channel.
   typedef enum logic [3:0] {
      CMD_NONE     = 4'd0,
      CMD_INIT     = 4'd1,
      CMD_PLAY     = 4'd2,
      CMD_INFO     = 4'd3,
      CMD_PWRDN    = 4'd4,
      CMD_NEXT     = 4'd5,
      CMD_PREV     = 4'd6,
      CMD_DISCUP   = 4'd7,
      CMD_DISCDN   = 4'd8,
      CMD_RANDOM   = 4'd9,
      CMD_FFWD     = 4'd10,
      CMD_FREV     = 4'd11
   } cmd_type;

   // Last reply index of the play and info streams.
   localparam logic [3:0] PLAY_LAST_INDEX = 4'd8;
   localparam logic [3:0] CART_LAST_INDEX = 4'd5;

   // Status codes and reset values of the editable play info bytes.
   localparam logic [7:0] STATUS_STOP  = 8'h02;
   localparam logic [7:0] STATUS_PLAY  = 8'h08;
   localparam logic [7:0] DISC_RESET   = 8'h01;
   localparam logic [7:0] TRACK_RESET  = 8'h01;
   localparam logic [7:0] WINDOW_RESET = 8'hFF;

   // Depth of the byte history kept ahead of the newest byte.
   localparam int unsigned HIST_DEPTH = 4;

   localparam int unsigned RSP_DATA_W = 40;

   // One result item.
   typedef struct packed {
      logic [7:0] track_number;
      logic [7:0] disc_number;
      logic [7:0] play_status;
      cmd_type    matched_cmd;
      logic [7:0] tx_byte;
      logic       tx_enable;
   } rsp_type;

   // Play info byte at a reply index; bytes past the table read as zero.
   function automatic logic [7:0] play_byte(input logic [3:0] idx,
                                            input logic [7:0] status,
                                            input logic [7:0] disc,
                                            input logic [7:0] track);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h00;
         4'd1:    b = status;
         4'd2:    b = 8'h00;
         4'd3:    b = disc;
         4'd4:    b = 8'h80;
         4'd5:    b = track;
         4'd6:    b = 8'hC7;
         4'd7:    b = 8'h0A;
         4'd8:    b = status;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Cartridge info byte at a reply index; bytes past the table read as zero.
   function automatic logic [7:0] cart_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h00;
         4'd1:    b = 8'hFC;
         4'd2:    b = 8'hFF;
         4'd3:    b = 8'h4A;
         4'd4:    b = 8'hFC;
         4'd5:    b = 8'hFF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

>>> src/cdcb_matcher.sv
// Priority matcher of the byte window against the command patterns.
`default_nettype none
module cdcb_matcher (
   input  wire logic [7:0]      w2,
   input  wire logic [7:0]      w3,
   input  wire logic [7:0]      w4,
   input  wire logic [7:0]      w5,
   input  wire logic [7:0]      w6,
   input  wire logic [7:0]      device_id,
   output cdcb_pkg::cmd_type    cmd
);

   logic       tail_init_a;
   logic       tail_init_b;
   logic       tail_play;
   logic       tail_mid;
   logic       id_at2;
   logic       id_at3;
   logic       id_at4;
   logic       play_id_at2;

   // Pattern pieces, some shared by several commands.
   assign tail_init_a = (w4 == 8'h07) && (w5 == 8'h1A) && (w6 == 8'hEE);
   assign tail_init_b = (w4 == 8'hED) && (w5 == 8'h80) && (w6 == 8'h86);
   assign tail_play   = (w3 == 8'h1B) && (w4 == 8'hE0) && (w5 == 8'h01) && (w6 == 8'h08);
   assign tail_mid    = (w3 == 8'h1B) && (w4 == 8'h2D) && (w6 == 8'h01);
   assign id_at2      = (w2 == device_id);
   assign id_at3      = (w3 == device_id);
   assign id_at4      = (w4 == device_id);
   // The play id is one above the device id, compared without wrap.
   assign play_id_at2 = ({1'b0, w2} == ({1'b0, device_id} + 9'd1));

   // First match in priority order wins.
   always_comb begin
      if (tail_init_a || tail_init_b) begin
         cmd = cdcb_pkg::CMD_INIT;
      end else if (play_id_at2 && tail_play) begin
         cmd = cdcb_pkg::CMD_PLAY;
      end else if (id_at4 && (w5 == 8'h1E) && (w6 == 8'hEF)) begin
         cmd = cdcb_pkg::CMD_INFO;
      end else if (id_at4 && (w5 == 8'h19) && (w6 == 8'h22)) begin
         cmd = cdcb_pkg::CMD_PWRDN;
      end else if (id_at2 && tail_mid && (w5 == 8'h40)) begin
         cmd = cdcb_pkg::CMD_NEXT;
      end else if (id_at2 && tail_mid && (w5 == 8'h00)) begin
         cmd = cdcb_pkg::CMD_PREV;
      end else if (id_at3 && (w4 == 8'h1A) && (w5 == 8'h50) && (w6 == 8'h41)) begin
         cmd = cdcb_pkg::CMD_DISCUP;
      end else if (id_at3 && (w4 == 8'h1A) && (w5 == 8'h50) && (w6 == 8'h01)) begin
         cmd = cdcb_pkg::CMD_DISCDN;
      end else if (id_at4 && (w5 == 8'h19) && (w6 == 8'h52)) begin
         cmd = cdcb_pkg::CMD_RANDOM;
      end else if (id_at4 && (w5 == 8'h19) && (w6 == 8'h29)) begin
         cmd = cdcb_pkg::CMD_FFWD;
      end else if (id_at4 && (w5 == 8'h19) && (w6 == 8'h2F)) begin
         cmd = cdcb_pkg::CMD_FREV;
      end else begin
         cmd = cdcb_pkg::CMD_NONE;
      end
   end

endmodule
`default_nettype wire

>>> src/cdcb_engine.sv
// Command state, byte history and play info, with the reply for one request.
`default_nettype none
module cdcb_engine (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [7:0]      rx_byte,
   input  wire logic [7:0]      device_id,
   output cdcb_pkg::rsp_type    rsp
);

   logic [7:0]          hist_ff [cdcb_pkg::HIST_DEPTH];
   cdcb_pkg::cmd_type   pending_ff;
   cdcb_pkg::cmd_type   pending_in;
   logic [3:0]          index_ff;
   logic [3:0]          index_in;
   logic [7:0]          status_ff;
   logic [7:0]          status_in;
   logic [7:0]          disc_ff;
   logic [7:0]          disc_in;
   logic [7:0]          track_ff;
   logic [7:0]          track_in;
   cdcb_pkg::cmd_type   match_cmd;
   cdcb_pkg::cmd_type   cmd;
   logic [4:0]          index_inc;
   logic [3:0]          play_next;
   logic [3:0]          cart_next;
   logic                tx_en;
   logic [7:0]          tx;

   // The window after the shift: history bytes, then the new byte.
   cdcb_matcher u_matcher (
      .w2        (hist_ff[0]),
      .w3        (hist_ff[1]),
      .w4        (hist_ff[2]),
      .w5        (hist_ff[3]),
      .w6        (rx_byte),
      .device_id (device_id),
      .cmd       (match_cmd)
   );

   // A pending command takes over from the matcher.
   always_comb begin
      case (pending_ff) inside
         cdcb_pkg::CMD_INIT, cdcb_pkg::CMD_PLAY, cdcb_pkg::CMD_INFO: cmd = pending_ff;
         default: cmd = match_cmd;
      endcase
   end

   // Next reply index of the play and info streams, wrapping after the last byte.
   assign index_inc = {1'b0, index_ff} + 5'd1;
   assign play_next = (index_inc > {1'b0, cdcb_pkg::PLAY_LAST_INDEX}) ? 4'd0 : index_inc[3:0];
   assign cart_next = (index_inc > {1'b0, cdcb_pkg::CART_LAST_INDEX}) ? 4'd0 : index_inc[3:0];

   // Command execution.
   always_comb begin
      tx_en      = 1'b0;
      tx         = 8'h00;
      pending_in = cdcb_pkg::CMD_NONE;
      index_in   = index_ff;
      status_in  = status_ff;
      disc_in    = disc_ff;
      track_in   = track_ff;
      unique case (cmd)
         cdcb_pkg::CMD_INIT: begin
            if (rx_byte == device_id) begin
               tx_en = 1'b1;
               tx    = device_id;
            end else begin
               pending_in = cdcb_pkg::CMD_INIT;
            end
         end
         cdcb_pkg::CMD_PWRDN: begin
            tx_en     = 1'b1;
            status_in = cdcb_pkg::STATUS_STOP;
         end
         cdcb_pkg::CMD_FREV: begin
            tx_en     = 1'b1;
            status_in = cdcb_pkg::STATUS_PLAY;
         end
         cdcb_pkg::CMD_NEXT:   track_in = track_ff + 8'd1;
         cdcb_pkg::CMD_PREV:   track_in = track_ff - 8'd1;
         cdcb_pkg::CMD_DISCUP: begin
            disc_in  = disc_ff + 8'd1;
            track_in = 8'h01;
         end
         cdcb_pkg::CMD_DISCDN: begin
            disc_in  = disc_ff - 8'd1;
            track_in = 8'h01;
         end
         cdcb_pkg::CMD_PLAY: begin
            tx_en      = 1'b1;
            tx         = cdcb_pkg::play_byte(index_ff, status_ff, disc_ff, track_ff);
            index_in   = play_next;
            pending_in = (play_next == 4'd0) ? cdcb_pkg::CMD_NONE : cdcb_pkg::CMD_PLAY;
         end
         cdcb_pkg::CMD_INFO: begin
            tx_en      = 1'b1;
            tx         = cdcb_pkg::cart_byte(index_ff);
            index_in   = cart_next;
            pending_in = (cart_next == 4'd0) ? cdcb_pkg::CMD_NONE : cdcb_pkg::CMD_INFO;
         end
         default: begin
         end
      endcase
   end

   // Result fields show the play info after this request.
   always_comb begin
      rsp.tx_enable    = tx_en;
      rsp.tx_byte      = tx;
      rsp.matched_cmd  = cmd;
      rsp.play_status  = status_in;
      rsp.disc_number  = disc_in;
      rsp.track_number = track_in;
   end

   // State update once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cdcb_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= cdcb_pkg::WINDOW_RESET;
         end
         pending_ff <= cdcb_pkg::CMD_NONE;
         index_ff   <= 4'd0;
         status_ff  <= cdcb_pkg::STATUS_STOP;
         disc_ff    <= cdcb_pkg::DISC_RESET;
         track_ff   <= cdcb_pkg::TRACK_RESET;
      end else if (step) begin
         for (int i = 0; i < cdcb_pkg::HIST_DEPTH - 1; i++) begin
            hist_ff[i] <= hist_ff[i + 1];
         end
         hist_ff[cdcb_pkg::HIST_DEPTH - 1] <= rx_byte;
         pending_ff <= pending_in;
         index_ff   <= index_in;
         status_ff  <= status_in;
         disc_ff    <= disc_in;
         track_ff   <= track_in;
      end
   end

endmodule
`default_nettype wire

>>> src/cd_changer_bus_responder.sv
// Top level of the CD changer bus responder: request and result registers and the id register.
`default_nettype none
// Each request carries one received bus byte and produces exactly one result. A request
// passes through an input register, then window compare, command execution and reply
// table read, and lands in a result register. One request can be accepted every cycle
// as long as results are taken. A stalled result holds the request in the input
// register. The user must write the device id register only while no request is in
// flight; the block itself does not enforce it.
module cd_changer_bus_responder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] tx_enable, [8:1] tx_byte, [12:9] matched_cmd, [20:13] play_status,
   // [28:21] disc_number, [36:29] track_number, [39:37] zero
   output logic [cdcb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0]          device_id_ff;
   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff;
   cdcb_pkg::rsp_type   out_ff;
   cdcb_pkg::rsp_type   rsp;
   logic                out_ready;
   logic                advance;

   // Pipeline flow: the result register frees when taken, the input register moves on.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || advance;

   cdcb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .device_id (device_id_ff),
      .rsp       (rsp)
   );

   // Device id register.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= 8'hE8;
      end else if (csr_we) begin
         device_id_ff <= csr_wdata;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(cdcb_pkg::RSP_DATA_W - $bits(cdcb_pkg::rsp_type)){1'b0}}, out_ff};

   // A result without a command never drives the bus.
   a_no_cmd_no_tx: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.matched_cmd == cdcb_pkg::CMD_NONE) |-> !out_ff.tx_enable)
      else $error("reply enabled without a command");

   // Status is always one of the two status codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.play_status == cdcb_pkg::STATUS_STOP) ||
                       (out_ff.play_status == cdcb_pkg::STATUS_PLAY))
      else $error("play status out of range");

   // A held request is not lost while the result side stalls.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled request dropped");

   // A request leaving the input register always lands in the result register.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result not registered");

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the CD changer bus responder: command sequences in, replies checked.
module testbench;
   import cdcb_pkg::*;

   // Command patterns as they sit at the tail of the byte window, newest byte lowest.
   localparam logic [23:0] INIT_PAT_A  = 24'h071AEE;
   localparam logic [23:0] INIT_PAT_B  = 24'hED8086;
   localparam logic [31:0] PLAY_TAIL   = 32'h1BE00108;
   localparam logic [15:0] INFO_TAIL   = 16'h1EEF;
   localparam logic [15:0] PWRDN_TAIL  = 16'h1922;
   localparam logic [31:0] NEXT_TAIL   = 32'h1B2D4001;
   localparam logic [31:0] PREV_TAIL   = 32'h1B2D0001;
   localparam logic [23:0] DISCUP_TAIL = 24'h1A5041;
   localparam logic [23:0] DISCDN_TAIL = 24'h1A5001;
   localparam logic [15:0] RANDOM_TAIL = 16'h1952;
   localparam logic [15:0] FFWD_TAIL   = 16'h1929;
   localparam logic [15:0] FREV_TAIL   = 16'h192F;
   // Cartridge reply bytes, index 0 in the top byte.
   localparam logic [47:0] CART_BYTES  = 48'h00FCFF4AFCFF;
   localparam int          PHASE_BYTES = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'h00;

   // Bus bytes waiting to be sent and replies waiting to arrive.
   logic [7:0] bus_bytes_q[$];
   rsp_type    reply_q[$];
   int         mismatch_count = 0;
   bit         idle_on = 1'b1;

   // Shadow state of the responder.
   logic [7:0] dev_id;
   logic [7:0] win [0:6];
   cmd_type    pending;
   logic [3:0] reply_idx;
   logic [7:0] play_info [0:8];

   rsp_type    seen;
   rsp_type    want;

   cd_changer_bus_responder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Find the highest-priority command in the current window.
   function automatic cmd_type match_window();
      logic [31:0] t4;
      logic [23:0] t3;
      logic [15:0] t2;
      t4 = {win[3], win[4], win[5], win[6]};
      t3 = t4[23:0];
      t2 = t4[15:0];
      if (t3 == INIT_PAT_A) return CMD_INIT;
      if (t3 == INIT_PAT_B) return CMD_INIT;
      // The play id is one above the device id and does not wrap.
      if ({1'b0, win[2]} == {1'b0, dev_id} + 9'd1 && t4 == PLAY_TAIL) return CMD_PLAY;
      if (win[4] == dev_id && t2 == INFO_TAIL) return CMD_INFO;
      if (win[4] == dev_id && t2 == PWRDN_TAIL) return CMD_PWRDN;
      if (win[2] == dev_id && t4 == NEXT_TAIL) return CMD_NEXT;
      if (win[2] == dev_id && t4 == PREV_TAIL) return CMD_PREV;
      if (win[3] == dev_id && t3 == DISCUP_TAIL) return CMD_DISCUP;
      if (win[3] == dev_id && t3 == DISCDN_TAIL) return CMD_DISCDN;
      if (win[4] == dev_id && t2 == RANDOM_TAIL) return CMD_RANDOM;
      if (win[4] == dev_id && t2 == FFWD_TAIL) return CMD_FFWD;
      if (win[4] == dev_id && t2 == FREV_TAIL) return CMD_FREV;
      return CMD_NONE;
   endfunction

   // Advance the shadow state by one received byte and return the reply it causes.
   function automatic rsp_type predict_reply(input logic [7:0] rx);
      rsp_type r;
      cmd_type c;
      int      i;
      r = '0;
      for (i = 0; i < 6; i++) win[i] = win[i + 1];
      win[6] = rx;
      if (pending == CMD_NONE) pending = match_window();
      c = pending;
      case (c)
         CMD_INIT: begin
            // Init holds until the device id itself comes by, then echoes it.
            if (rx == dev_id) begin
               r.tx_enable = 1'b1;
               r.tx_byte   = dev_id;
               pending     = CMD_NONE;
            end
         end
         CMD_PWRDN: begin
            r.tx_enable  = 1'b1;
            pending      = CMD_NONE;
            play_info[1] = STATUS_STOP;
            play_info[8] = STATUS_STOP;
         end
         CMD_FREV: begin
            r.tx_enable  = 1'b1;
            pending      = CMD_NONE;
            play_info[1] = STATUS_PLAY;
            play_info[8] = STATUS_PLAY;
         end
         CMD_NEXT: begin
            pending      = CMD_NONE;
            play_info[5] = play_info[5] + 8'd1;
         end
         CMD_PREV: begin
            pending      = CMD_NONE;
            play_info[5] = play_info[5] - 8'd1;
         end
         CMD_DISCUP: begin
            pending      = CMD_NONE;
            play_info[3] = play_info[3] + 8'd1;
            play_info[5] = TRACK_RESET;
         end
         CMD_DISCDN: begin
            pending      = CMD_NONE;
            play_info[3] = play_info[3] - 8'd1;
            play_info[5] = TRACK_RESET;
         end
         CMD_RANDOM, CMD_FFWD: begin
            pending = CMD_NONE;
         end
         CMD_PLAY: begin
            r.tx_enable = 1'b1;
            r.tx_byte   = (reply_idx < 4'd9) ? play_info[reply_idx] : 8'h00;
            reply_idx   = (reply_idx >= PLAY_LAST_INDEX) ? 4'd0 : reply_idx + 4'd1;
            if (reply_idx == 4'd0) pending = CMD_NONE;
         end
         CMD_INFO: begin
            r.tx_enable = 1'b1;
            r.tx_byte   = (reply_idx < 4'd6) ? CART_BYTES[47 - 8 * reply_idx -: 8] : 8'h00;
            reply_idx   = (reply_idx >= CART_LAST_INDEX) ? 4'd0 : reply_idx + 4'd1;
            if (reply_idx == 4'd0) pending = CMD_NONE;
         end
         default: ;
      endcase
      r.matched_cmd  = c;
      r.play_status  = play_info[1];
      r.disc_number  = play_info[3];
      r.track_number = play_info[5];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] exp_val);
      $display("mismatch in %s: got %h, expected %h", what, got, exp_val);
      mismatch_count++;
   endtask

   // Driver: sends queued bus bytes and predicts the reply of each accepted request.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         dev_id    = 8'hE8;
         for (int k = 0; k < 7; k++) win[k] = WINDOW_RESET;
         pending   = CMD_NONE;
         reply_idx = 4'd0;
         play_info = '{8'h00, STATUS_STOP, 8'h00, DISC_RESET, 8'h80,
                       TRACK_RESET, 8'hC7, 8'h0A, STATUS_STOP};
      end else begin
         if (req_tvalid && req_tready) reply_q.push_back(predict_reply(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (bus_bytes_q.size() != 0 && !(idle_on && $urandom_range(99) < 27)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= bus_bytes_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes replies with random back-pressure and checks them in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_type'(rsp_tdata[36:0]);
            if (rsp_tdata[39:37] != 3'b000)
               report_mismatch("padding", 8'(rsp_tdata[39:37]), 8'h00);
            if (reply_q.size() == 0) begin
               report_mismatch("reply with no request waiting", 8'(seen.tx_byte), 8'h00);
            end else begin
               want = reply_q.pop_front();
               if (seen.tx_enable !== want.tx_enable)
                  report_mismatch("tx_enable", 8'(seen.tx_enable), 8'(want.tx_enable));
               if (seen.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", seen.tx_byte, want.tx_byte);
               if (seen.matched_cmd !== want.matched_cmd)
                  report_mismatch("matched_cmd", 8'(seen.matched_cmd), 8'(want.matched_cmd));
               if (seen.play_status !== want.play_status)
                  report_mismatch("play_status", seen.play_status, want.play_status);
               if (seen.disc_number !== want.disc_number)
                  report_mismatch("disc_number", seen.disc_number, want.disc_number);
               if (seen.track_number !== want.track_number)
                  report_mismatch("track_number", seen.track_number, want.track_number);
            end
         end
         rsp_tready <= !(idle_on && $urandom_range(99) < 27);
      end
   end

   // Block until every byte is sent and every reply is back, then let the pipeline settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (bus_bytes_q.size() != 0 || req_tvalid || reply_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_device_id(input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      dev_id = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queue the bytes of one command; a broken one has a byte changed or its tail cut off.
   task automatic queue_command(input cmd_type c, input bit broken, inout int count);
      logic [7:0] seq[$];
      int         fill;
      int         k;
      fill = 0;
      case (c)
         CMD_INIT: begin
            if ($urandom_range(1)) seq = '{INIT_PAT_A[23:16], INIT_PAT_A[15:8], INIT_PAT_A[7:0]};
            else seq = '{INIT_PAT_B[23:16], INIT_PAT_B[15:8], INIT_PAT_B[7:0]};
            repeat ($urandom_range(2)) seq.push_back(8'($urandom_range(255)));
            seq.push_back(dev_id);
         end
         CMD_PLAY: begin
            seq  = '{dev_id + 8'd1, PLAY_TAIL[31:24], PLAY_TAIL[23:16], PLAY_TAIL[15:8],
                     PLAY_TAIL[7:0]};
            fill = 9;
         end
         CMD_INFO: begin
            seq  = '{dev_id, INFO_TAIL[15:8], INFO_TAIL[7:0]};
            fill = 6;
         end
         CMD_PWRDN:  seq = '{dev_id, PWRDN_TAIL[15:8], PWRDN_TAIL[7:0]};
         CMD_NEXT:   seq = '{dev_id, NEXT_TAIL[31:24], NEXT_TAIL[23:16], NEXT_TAIL[15:8],
                             NEXT_TAIL[7:0]};
         CMD_PREV:   seq = '{dev_id, PREV_TAIL[31:24], PREV_TAIL[23:16], PREV_TAIL[15:8],
                             PREV_TAIL[7:0]};
         CMD_DISCUP: seq = '{dev_id, DISCUP_TAIL[23:16], DISCUP_TAIL[15:8], DISCUP_TAIL[7:0]};
         CMD_DISCDN: seq = '{dev_id, DISCDN_TAIL[23:16], DISCDN_TAIL[15:8], DISCDN_TAIL[7:0]};
         CMD_RANDOM: seq = '{dev_id, RANDOM_TAIL[15:8], RANDOM_TAIL[7:0]};
         CMD_FFWD:   seq = '{dev_id, FFWD_TAIL[15:8], FFWD_TAIL[7:0]};
         CMD_FREV:   seq = '{dev_id, FREV_TAIL[15:8], FREV_TAIL[7:0]};
         default:    seq = '{8'($urandom_range(255))};
      endcase
      if (broken) begin
         k = $urandom_range(seq.size() - 1);
         if ($urandom_range(1)) seq[k] = 8'($urandom_range(255));
         else while (seq.size() > k + 1) void'(seq.pop_back());
      end
      // Bytes that clock out a streamed reply carry random content.
      repeat (fill) seq.push_back(8'($urandom_range(255)));
      foreach (seq[k2]) bus_bytes_q.push_back(seq[k2]);
      count += seq.size();
   endtask

   // Random traffic: mostly whole commands, with some noise and broken commands.
   task automatic queue_random_traffic(input int target);
      int count;
      int roll;
      count = 0;
      while (count < target) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            queue_command(cmd_type'($urandom_range(11, 1)), 1'b0, count);
         end else if (roll < 93) begin
            queue_command(cmd_type'($urandom_range(11, 1)), 1'b1, count);
         end else begin
            bus_bytes_q.push_back(8'($urandom_range(255)));
            count++;
         end
         repeat ($urandom_range(2)) begin
            bus_bytes_q.push_back(8'($urandom_range(255)));
            count++;
         end
      end
   endtask

   // Stimulus: one phase per device id, each split by a full drain.
   initial begin
      logic [7:0] id_val;
      int         count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0:       id_val = 8'hE8;
            1:       id_val = 8'hEE;
            2:       id_val = 8'h00;
            3:       id_val = 8'hFF;
            default: id_val = 8'($urandom_range(254, 1));
         endcase
         write_device_id(id_val);
         // The third phase runs with no idling on either side.
         idle_on = (phase != 2);
         count = 0;
         case (phase)
            0: begin
               // Power down, track step down to zero, disc wrap below zero, fast reverse.
               queue_command(CMD_INIT, 1'b0, count);
               queue_command(CMD_PWRDN, 1'b0, count);
               queue_command(CMD_PREV, 1'b0, count);
               queue_command(CMD_DISCDN, 1'b0, count);
               queue_command(CMD_DISCDN, 1'b0, count);
               queue_command(CMD_FREV, 1'b0, count);
               bus_bytes_q.push_back(8'h00);
               bus_bytes_q.push_back(8'hFF);
            end
            1: begin
               // The init pattern ends in the device id, so the echo comes at once.
               bus_bytes_q.push_back(INIT_PAT_A[23:16]);
               bus_bytes_q.push_back(INIT_PAT_A[15:8]);
               bus_bytes_q.push_back(INIT_PAT_A[7:0]);
            end
            3: begin
               // With the top id the play id would need nine bits and never matches.
               queue_command(CMD_PLAY, 1'b0, count);
               queue_command(CMD_INFO, 1'b0, count);
            end
            default: ;
         endcase
         queue_random_traffic(PHASE_BYTES / 2);
         wait_drained();
         queue_random_traffic(PHASE_BYTES / 2);
      end
      wait_drained();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #8000000;
      $display("FAILURE");
      $finish;
   end

endmodule
